>>> src/fmaa_pkg.sv
// ----------------------------------------------------------------------------
// fmaa_pkg: shared types and constants for the first-match address ACL
// Function and status codes, the decoded command word, the stored rule and
// the result word.
// ----------------------------------------------------------------------------
`default_nettype none

package fmaa_pkg;

    localparam int ADDR_W = 32;

    // Input function codes
    localparam logic [1:0] FN_ADD   = 2'd0;
    localparam logic [1:0] FN_TEST  = 2'd1;
    localparam logic [1:0] FN_READ  = 2'd2;
    localparam logic [1:0] FN_CLEAR = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADLEN = 2'd2;
    localparam logic [1:0] ST_NOIDX  = 2'd3;

    localparam logic [ADDR_W-1:0] MASK_ALL   = 32'hFFFF_FFFF;
    localparam logic [5:0]        FULL_LEN   = 6'd32;
    localparam logic [5:0]        MAX_PREFIX = 6'd48;

    // Decoded operation handed from front to back
    typedef enum logic [2:0] {
        OP_ADD,
        OP_TEST,
        OP_READ,
        OP_CLEAR,
        OP_BADLEN
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] mask;
        logic              allow;
        logic [3:0]        index;
    } t_cmd;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] mask;
        logic              allow;
    } t_rule;

    typedef struct packed {
        logic [1:0]        status;
        logic              permitted;
        logic              matched;
        logic [3:0]        match_index;
        logic [4:0]        entry_count;
        logic [ADDR_W-1:0] entry_address;
        logic [ADDR_W-1:0] entry_mask;
        logic              entry_allow;
    } t_res;

    // Mask with min(len, 32) leading ones
    function automatic logic [ADDR_W-1:0] prefix_to_mask(input logic [5:0] len);
        logic [ADDR_W-1:0] m;
        if (len >= FULL_LEN) begin
            m = MASK_ALL;
        end else begin
            m = ~(MASK_ALL >> len[4:0]);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

>>> src/fmaa_ram.sv
// ----------------------------------------------------------------------------
// fmaa_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fmaa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> src/fmaa_fifo.sv
// ----------------------------------------------------------------------------
// fmaa_fifo: two-entry queue
// Decouples producer and consumer; push and pop may happen in one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fmaa_fifo #(
    parameter type t_word = logic
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_word     i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_word     o_data
);

    t_word      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Store incoming word
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/fmaa_front.sv
// ----------------------------------------------------------------------------
// fmaa_front: command classifier
// Decodes the function, builds the rule mask, masks the rule address and
// flags prefix lengths that are out of range.
// ----------------------------------------------------------------------------
`default_nettype none

module fmaa_front (
    input  wire logic [1:0]  i_func,
    input  wire logic [31:0] i_address,
    input  wire logic [31:0] i_full_mask,
    input  wire logic [5:0]  i_prefix_length,
    input  wire logic        i_use_prefix,
    input  wire logic        i_allow,
    input  wire logic [3:0]  i_entry_index,
    output fmaa_pkg::t_cmd   o_cmd
);

    import fmaa_pkg::*;

    logic [ADDR_W-1:0] w_mask;
    logic              w_badlen;

    // Pick mask source and check prefix range
    assign w_mask   = i_use_prefix ? prefix_to_mask(i_prefix_length) : i_full_mask;
    assign w_badlen = i_use_prefix && (i_prefix_length > MAX_PREFIX);

    // Build command word
    always_comb begin
        o_cmd.mask    = w_mask;
        o_cmd.allow   = i_allow;
        o_cmd.index   = i_entry_index;
        o_cmd.address = i_address;
        unique case (i_func)
            FN_ADD: begin
                o_cmd.op      = w_badlen ? OP_BADLEN : OP_ADD;
                o_cmd.address = i_address & w_mask;
            end
            FN_TEST:  o_cmd.op = OP_TEST;
            FN_READ:  o_cmd.op = OP_READ;
            FN_CLEAR: o_cmd.op = OP_CLEAR;
            default:  o_cmd.op = OP_CLEAR;
        endcase
    end

endmodule

`default_nettype wire

>>> src/fmaa_back.sv
// ----------------------------------------------------------------------------
// fmaa_back: rule table engine
// Holds the rule count and rule RAM, executes commands, and scans rules in
// order, one per cycle, for the first match.
// ----------------------------------------------------------------------------
`default_nettype none

module fmaa_back #(
    parameter int MAX_RULES = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  fmaa_pkg::t_cmd i_cmd,
    input  wire logic      i_cmd_valid,
    output logic           o_cmd_pop,
    output fmaa_pkg::t_res o_res,
    output logic           o_res_push,
    input  wire logic      i_res_full
);

    import fmaa_pkg::*;

    localparam int IW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CW = $clog2(MAX_RULES + 1);
    localparam int XW = (CW > 4) ? CW : 4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [IW-1:0]   r_cmp_idx, n_cmp_idx;
    logic [31:0]     r_addr, n_addr;

    logic            w_we;
    logic [IW-1:0]   w_waddr;
    t_rule           w_wdata;
    logic [IW-1:0]   w_raddr;
    t_rule           w_rdata;
    logic            w_hit;
    logic            w_last;
    logic            w_full;
    logic            w_idx_ok;

    fmaa_ram #(
        .WIDTH ($bits(t_rule)),
        .DEPTH (MAX_RULES),
        .AW    (IW)
    ) u_rules (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_hit    = ((r_addr & w_rdata.mask) == w_rdata.address);
    assign w_last   = ((CW'(r_cmp_idx) + CW'(1)) == r_count);
    assign w_full   = (r_count >= CW'(MAX_RULES));
    assign w_idx_ok = (XW'(i_cmd.index) < XW'(r_count));
    assign w_waddr  = IW'(r_count);
    assign w_wdata  = '{address: i_cmd.address, mask: i_cmd.mask, allow: i_cmd.allow};

    // Sequence commands and form results
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_cmp_idx  = r_cmp_idx;
        n_addr     = r_addr;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        w_we       = 1'b0;
        w_raddr    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_ADD: begin
                            o_res_push = 1'b1;
                            if (w_full) begin
                                o_res.status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_BADLEN: begin
                            o_res_push   = 1'b1;
                            o_res.status = ST_BADLEN;
                        end
                        OP_CLEAR: begin
                            o_res_push = 1'b1;
                            n_count    = '0;
                        end
                        OP_READ: begin
                            if (w_idx_ok) begin
                                w_raddr = IW'(i_cmd.index);
                                n_state = S_READ;
                            end else begin
                                o_res_push   = 1'b1;
                                o_res.status = ST_NOIDX;
                            end
                        end
                        OP_TEST: begin
                            if (r_count == '0) begin
                                o_res_push      = 1'b1;
                                o_res.permitted = 1'b1;
                            end else begin
                                w_raddr   = '0;
                                n_addr    = i_cmd.address;
                                n_cmp_idx = '0;
                                n_state   = S_SCAN;
                            end
                        end
                        default: begin
                            o_res_push = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                o_res_push          = 1'b1;
                o_res.entry_address = w_rdata.address;
                o_res.entry_mask    = w_rdata.mask;
                o_res.entry_allow   = w_rdata.allow;
                n_state             = S_IDLE;
            end
            S_SCAN: begin
                if (w_hit) begin
                    o_res_push        = 1'b1;
                    o_res.matched     = 1'b1;
                    o_res.permitted   = w_rdata.allow;
                    o_res.match_index = 4'(r_cmp_idx);
                    n_state           = S_IDLE;
                end else if (w_last) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    w_raddr   = r_cmp_idx + IW'(1);
                    n_cmp_idx = r_cmp_idx + IW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_res.entry_count = 5'(n_count);
    end

    // Hold state, count and scan context
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        r_addr    <= n_addr;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RULES))
        else $error("rule count above table size");

    a_no_res_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into full queue");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CW'(r_cmp_idx) < r_count))
        else $error("scan index past stored rules");

    a_write_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> (r_count == $past(r_count) + CW'(1)))
        else $error("rule write without count advance");

endmodule

`default_nettype wire

>>> src/first_match_address_acl_core.sv
// ----------------------------------------------------------------------------
// first_match_address_acl_core: ordered IPv4 rule table with first-match test
// Top level: classifier front, command queue, table engine, result queue.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive the fields and raise push; the word is taken
//   on a clock edge where full is low. Results come out of a queue: while
//   empty is low the oldest result sits on the o_ ports, and pop takes it.
//   Every input word yields exactly one result word, in order.
// Timing:
//   Add, clear and rejected adds finish in the engine's idle state; a read
//   also passes the read state. A test on an empty table finishes in idle;
//   otherwise the scan state checks rules in order up to the first match or
//   the last rule, since the rule RAM is read one entry per cycle through its
//   single read port. A word passes both registered queues before empty falls.
// Reset:
//   Synchronous, active low; the rule count and both queues are cleared. Rule
//   RAM contents are not cleared and need no sweep.
// Stall:
//   When pop stays low the result queue fills, the engine waits, the command
//   queue fills and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module first_match_address_acl_core #(
    parameter int MAX_RULES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_func,
    input  wire logic [31:0] i_address,
    input  wire logic [31:0] i_full_mask,
    input  wire logic [5:0]  i_prefix_length,
    input  wire logic        i_use_prefix,
    input  wire logic        i_allow,
    input  wire logic [3:0]  i_entry_index,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_status,
    output logic             o_permitted,
    output logic             o_matched,
    output logic [3:0]       o_match_index,
    output logic [4:0]       o_entry_count,
    output logic [31:0]      o_entry_address,
    output logic [31:0]      o_entry_mask,
    output logic             o_entry_allow
);

    import fmaa_pkg::*;

    t_cmd w_cmd_in;
    t_cmd w_cmd_out;
    logic w_cmd_valid;
    logic w_cmd_pop;
    t_res w_res_in;
    t_res w_res_out;
    logic w_res_push;
    logic w_res_full;
    logic w_res_valid;

    // Classify incoming word
    fmaa_front u_front (
        .i_func          (i_func),
        .i_address       (i_address),
        .i_full_mask     (i_full_mask),
        .i_prefix_length (i_prefix_length),
        .i_use_prefix    (i_use_prefix),
        .i_allow         (i_allow),
        .i_entry_index   (i_entry_index),
        .o_cmd           (w_cmd_in)
    );

    // Queue commands between front and engine
    fmaa_fifo #(
        .t_word (t_cmd)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_cmd_in),
        .o_full  (full),
        .i_pop   (w_cmd_pop),
        .o_valid (w_cmd_valid),
        .o_data  (w_cmd_out)
    );

    // Execute against the rule table
    fmaa_back #(
        .MAX_RULES (MAX_RULES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd_out),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .o_res       (w_res_in),
        .o_res_push  (w_res_push),
        .i_res_full  (w_res_full)
    );

    // Queue results for the receiver
    fmaa_fifo #(
        .t_word (t_res)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_valid (w_res_valid),
        .o_data  (w_res_out)
    );

    assign empty           = !w_res_valid;
    assign o_status        = w_res_out.status;
    assign o_permitted     = w_res_out.permitted;
    assign o_matched       = w_res_out.matched;
    assign o_match_index   = w_res_out.match_index;
    assign o_entry_count   = w_res_out.entry_count;
    assign o_entry_address = w_res_out.entry_address;
    assign o_entry_mask    = w_res_out.entry_mask;
    assign o_entry_allow   = w_res_out.entry_allow;

endmodule

`default_nettype wire

>>> verif/first_match_address_acl_core_tb.sv
// ----------------------------------------------------------------------------
// first_match_address_acl_core_tb: self-checking bench for the rule table
// Feeds add, test, read and clear words through the input queue with random
// gaps and output stalls. Predicts every result word from a local copy of the
// rule table and compares each popped word field by field, in order.
// ----------------------------------------------------------------------------
module first_match_address_acl_core_tb;

    import fmaa_pkg::*;

    localparam int ACL_DEPTH = 16;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] address;
        logic [31:0] full_mask;
        logic [5:0]  prefix_length;
        logic        use_prefix;
        logic        allow;
        logic [3:0]  entry_index;
    } t_acl_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_func = FN_TEST;
    logic [31:0] i_address = '0;
    logic [31:0] i_full_mask = '0;
    logic [5:0]  i_prefix_length = '0;
    logic        i_use_prefix = 1'b0;
    logic        i_allow = 1'b0;
    logic [3:0]  i_entry_index = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_status;
    logic        o_permitted;
    logic        o_matched;
    logic [3:0]  o_match_index;
    logic [4:0]  o_entry_count;
    logic [31:0] o_entry_address;
    logic [31:0] o_entry_mask;
    logic        o_entry_allow;

    // Words waiting to be offered, and results waiting to be popped
    t_acl_word pend_q[$];
    t_res      acl_expect_q[$];
    t_acl_word cur_word;

    // Local copy of the rule table
    logic [31:0] rule_addr_m [ACL_DEPTH];
    logic [31:0] rule_mask_m [ACL_DEPTH];
    logic        rule_allow_m [ACL_DEPTH];
    int          rule_cnt_m = 0;

    // Stimulus-side view of the table, used only to shape the words
    logic [31:0] gen_addr [ACL_DEPTH];
    int          gen_count = 0;

    int   mismatch_count = 0;
    int   send_wait = 0;
    bit   send_burst = 1'b0;
    int   recv_wait = 0;
    bit   recv_burst = 1'b0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;
    int   words_popped = 0;
    logic rx_holding = 1'b0;

    first_match_address_acl_core #(
        .MAX_RULES(ACL_DEPTH)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_func(i_func),
        .i_address(i_address),
        .i_full_mask(i_full_mask),
        .i_prefix_length(i_prefix_length),
        .i_use_prefix(i_use_prefix),
        .i_allow(i_allow),
        .i_entry_index(i_entry_index),
        .empty(empty),
        .pop(pop),
        .o_status(o_status),
        .o_permitted(o_permitted),
        .o_matched(o_matched),
        .o_match_index(o_match_index),
        .o_entry_count(o_entry_count),
        .o_entry_address(o_entry_address),
        .o_entry_mask(o_entry_mask),
        .o_entry_allow(o_entry_allow)
    );

    always #2 i_clk = ~i_clk;

    // Compute the result of one word and update the local table
    function automatic t_res acl_predict(input t_acl_word w);
        t_res        r;
        logic [31:0] m;
        bit          found;
        r = '0;
        found = 1'b0;
        case (w.func)
            FN_ADD: begin
                if (w.use_prefix && w.prefix_length > MAX_PREFIX) begin
                    r.status = ST_BADLEN;
                end else if (rule_cnt_m >= ACL_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    m = w.full_mask;
                    if (w.use_prefix) begin
                        for (int k = 0; k < 32; k++) begin
                            m[31-k] = (k < w.prefix_length);
                        end
                    end
                    rule_addr_m[rule_cnt_m] = w.address & m;
                    rule_mask_m[rule_cnt_m] = m;
                    rule_allow_m[rule_cnt_m] = w.allow;
                    rule_cnt_m++;
                end
            end
            FN_TEST: begin
                if (rule_cnt_m == 0) begin
                    r.permitted = 1'b1;
                end else begin
                    for (int k = 0; k < rule_cnt_m; k++) begin
                        if (!found && (w.address & rule_mask_m[k]) == rule_addr_m[k]) begin
                            found = 1'b1;
                            r.matched = 1'b1;
                            r.match_index = k[3:0];
                            r.permitted = rule_allow_m[k];
                        end
                    end
                end
            end
            FN_READ: begin
                if (w.entry_index >= rule_cnt_m) begin
                    r.status = ST_NOIDX;
                end else begin
                    r.entry_address = rule_addr_m[w.entry_index];
                    r.entry_mask = rule_mask_m[w.entry_index];
                    r.entry_allow = rule_allow_m[w.entry_index];
                end
            end
            default: begin
                rule_cnt_m = 0;
            end
        endcase
        r.entry_count = rule_cnt_m[4:0];
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                          input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    function automatic void check_result(input t_res e);
        compare_field("status", 32'(e.status), 32'(o_status));
        compare_field("permitted", 32'(e.permitted), 32'(o_permitted));
        compare_field("matched", 32'(e.matched), 32'(o_matched));
        compare_field("match_index", 32'(e.match_index), 32'(o_match_index));
        compare_field("entry_count", 32'(e.entry_count), 32'(o_entry_count));
        compare_field("entry_address", e.entry_address, o_entry_address);
        compare_field("entry_mask", e.entry_mask, o_entry_mask);
        compare_field("entry_allow", 32'(e.entry_allow), 32'(o_entry_allow));
    endfunction

    // Word with every field random; callers override what matters
    function automatic t_acl_word rand_word();
        t_acl_word w;
        w.func = 2'($urandom_range(0, 3));
        w.address = $urandom;
        w.full_mask = $urandom;
        w.prefix_length = 6'($urandom_range(0, 63));
        w.use_prefix = 1'($urandom_range(0, 1));
        w.allow = 1'($urandom_range(0, 1));
        w.entry_index = 4'($urandom_range(0, 15));
        return w;
    endfunction

    function automatic void queue_add(input logic [31:0] addr, input logic use_p,
                                      input logic [5:0] len, input logic [31:0] mask,
                                      input logic allow);
        t_acl_word w;
        w = rand_word();
        w.func = FN_ADD;
        w.address = addr;
        w.use_prefix = use_p;
        w.prefix_length = len;
        w.full_mask = mask;
        w.allow = allow;
        pend_q.push_back(w);
        if (!(use_p && len > MAX_PREFIX) && gen_count < ACL_DEPTH) begin
            gen_addr[gen_count] = addr;
            gen_count++;
        end
    endfunction

    function automatic void queue_test(input logic [31:0] addr);
        t_acl_word w;
        w = rand_word();
        w.func = FN_TEST;
        w.address = addr;
        pend_q.push_back(w);
    endfunction

    function automatic void queue_read(input logic [3:0] idx);
        t_acl_word w;
        w = rand_word();
        w.func = FN_READ;
        w.entry_index = idx;
        pend_q.push_back(w);
    endfunction

    function automatic void queue_clear();
        t_acl_word w;
        w = rand_word();
        w.func = FN_CLEAR;
        pend_q.push_back(w);
        gen_count = 0;
    endfunction

    // Driver: offer pending words, predict each one as it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!(push && full)) begin
            if (push) begin
                acl_expect_q.push_back(acl_predict(cur_word));
            end
            if (send_wait > 0) begin
                send_wait--;
                push <= 1'b0;
            end else if (pend_q.size() != 0) begin
                cur_word = pend_q.pop_front();
                i_func <= cur_word.func;
                i_address <= cur_word.address;
                i_full_mask <= cur_word.full_mask;
                i_prefix_length <= cur_word.prefix_length;
                i_use_prefix <= cur_word.use_prefix;
                i_allow <= cur_word.allow;
                i_entry_index <= cur_word.entry_index;
                push <= 1'b1;
                send_wait = (send_burst || rx_holding) ? 0 : $urandom_range(0, 12);
                if ($urandom_range(0, 39) == 0) begin
                    send_burst = !send_burst;
                end
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Receiver hold: stall pops once for a long stretch so the input backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_holding <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rx_holding <= (hold_left != 0);
        end else if (!hold_done && words_popped >= 250) begin
            hold_done = 1'b1;
            hold_left = 400;
            rx_holding <= 1'b1;
        end
    end

    // Monitor: check each popped word against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (acl_expect_q.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got status %h",
                             $time, o_status);
                    mismatch_count++;
                end else begin
                    check_result(acl_expect_q.pop_front());
                end
                words_popped++;
                recv_wait = recv_burst ? 0 : $urandom_range(0, 12);
                if ($urandom_range(0, 39) == 0) begin
                    recv_burst = !recv_burst;
                end
            end
            if (rx_holding) begin
                pop <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        int           sel;
        logic [31:0]  addr;
        logic [31:0]  mask;
        logic [5:0]   len;

        // Directed: empty table, bad lengths, prefix edges, full table, clear
        queue_test(32'hFFFF_FFFF);
        queue_read(4'd0);
        queue_add($urandom, 1'b1, 6'd49, $urandom, 1'b1);
        queue_add($urandom, 1'b1, 6'd63, $urandom, 1'b1);
        queue_add(32'hC0A8_0101, 1'b1, 6'd32, $urandom, 1'b0);
        queue_add(32'h0A00_0000, 1'b1, 6'd8, $urandom, 1'b1);
        queue_test(32'h0A12_3456);
        queue_test(32'h0B00_0000);
        queue_add(32'hFFFF_FFFF, 1'b0, 6'($urandom), 32'h8000_0000, 1'b1);
        queue_add(32'h1234_5678, 1'b1, 6'd33, $urandom, 1'b0);
        queue_add(32'hFFFF_FFFF, 1'b1, 6'd48, $urandom, 1'b1);
        queue_test(32'h8000_0000);
        queue_add(32'hFFFF_FFFF, 1'b1, 6'd0, $urandom, 1'b0);
        for (int k = 0; k < 10; k++) begin
            queue_add($urandom, 1'b0, 6'($urandom), (k == 0) ? 32'hFFFF_FFFF : $urandom,
                      1'($urandom_range(0, 1)));
        end
        queue_add($urandom, 1'b0, 6'($urandom), 32'h0000_0000, 1'b1);
        queue_read(4'd15);
        queue_clear();
        queue_read(4'd0);
        queue_test($urandom);

        // Random: rule sessions with matching and missing tests
        for (int n = 0; n < 900; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 2 || (gen_count == ACL_DEPTH && $urandom_range(0, 3) == 0)) begin
                queue_clear();
            end else if (sel < 35) begin
                len = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(49, 63)
                                                     : $urandom_range(0, 48));
                case ($urandom_range(0, 2))
                    0: mask = $urandom;
                    1: mask = 32'hFFFF_FFFF;
                    default: mask = 32'hFFFF_FFFF << $urandom_range(0, 32);
                endcase
                queue_add($urandom, 1'($urandom_range(0, 1)), len, mask,
                          1'($urandom_range(0, 1)));
            end else if (sel < 80) begin
                addr = $urandom;
                if (gen_count > 0 && $urandom_range(0, 3) != 0) begin
                    addr = gen_addr[$urandom_range(0, gen_count - 1)]
                           ^ ($urandom >> $urandom_range(0, 32));
                end
                queue_test(addr);
            end else begin
                queue_read(4'($urandom_range(0, 15)));
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all words taken and all results checked
        while (pend_q.size() != 0 || push || acl_expect_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && acl_expect_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
